### hw/rtl/sca_pkg.sv
// Types, constants and tables shared by the size-class slab allocator.
package sca_pkg;

    localparam int MIN_BLOCK_BYTES = 8;
    localparam int NUM_CLASSES     = 8;
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGES_PER_CLASS = 4;

    localparam int CLS_W   = 3;
    localparam int PG_W    = 2;
    localparam int PAGE_W  = CLS_W + PG_W;
    localparam int SLOT_W  = 9;
    localparam int LINK_W  = SLOT_W + 1;
    localparam int MEM_AW  = PAGE_W + SLOT_W;
    localparam int OFF_W   = 17;
    localparam int RECIP_W = 17;
    localparam int RECIP_SH = 16;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(512);
    localparam logic [7:0] MAX_RSIZE = 8'(MIN_BLOCK_BYTES * NUM_CLASSES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [6:0]  request_size;
        logic [2:0]  alignment_log2;
        logic [16:0] block_offset;
    } t_in;

    typedef struct packed {
        logic [16:0] granted_offset;
        logic [1:0]  status;
    } t_out;

    // Classified command passed from front to back
    typedef struct packed {
        logic              op;
        logic              bad_size;
        logic [CLS_W-1:0]  cls;
        logic [PAGE_W-1:0] gp;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    // Slots per page for each class: PAGE_BYTES / block size
    function automatic logic [LINK_W-1:0] slots_in_page(input logic [CLS_W-1:0] cls);
        logic [LINK_W-1:0] n;
        unique case (cls)
            3'd0: n = 10'd512;
            3'd1: n = 10'd256;
            3'd2: n = 10'd170;
            3'd3: n = 10'd128;
            3'd4: n = 10'd102;
            3'd5: n = 10'd85;
            3'd6: n = 10'd73;
            3'd7: n = 10'd64;
            default: n = 10'd64;
        endcase
        return n;
    endfunction

    // ceil(2^16 / (cls+1)); exact floor division for 9-bit dividends
    function automatic logic [RECIP_W-1:0] recip(input logic [CLS_W-1:0] cls);
        logic [RECIP_W-1:0] r;
        unique case (cls)
            3'd0: r = 17'd65536;
            3'd1: r = 17'd32768;
            3'd2: r = 17'd21846;
            3'd3: r = 17'd16384;
            3'd4: r = 17'd13108;
            3'd5: r = 17'd10923;
            3'd6: r = 17'd9363;
            3'd7: r = 17'd8192;
            default: r = 17'd8192;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/sca_front.sv
// Front end: classifies allocate and free requests into commands.
module sca_front (
    input  sca_pkg::t_in  i_req,
    output sca_pkg::t_cmd o_cmd
);
    import sca_pkg::*;

    logic [7:0]            amask;
    logic [7:0]            sum;
    logic [7:0]            rsize;
    logic [7:0]            rsize_m1;
    logic [8:0]            x;
    logic [CLS_W-1:0]      fcls;
    logic [25:0]           prod;

    // Round the size up and pick the class
    assign amask    = (8'd1 << i_req.alignment_log2) - 8'd1;
    assign sum      = {1'b0, i_req.request_size} + amask;
    assign rsize    = sum & ~amask;
    assign rsize_m1 = rsize - 8'd1;

    // Split the offset; divide the in-page block index by the class factor
    assign fcls = i_req.block_offset[16:14];
    assign x    = i_req.block_offset[11:3];
    assign prod = 26'(x) * 26'(recip(fcls));

    always_comb begin
        o_cmd.op       = i_req.operation;
        o_cmd.bad_size = (rsize == 8'd0) || (rsize > MAX_RSIZE);
        o_cmd.cls      = (i_req.operation == OP_FREE) ? fcls : rsize_m1[5:3];
        o_cmd.gp       = i_req.block_offset[16:12];
        o_cmd.slot     = prod[RECIP_SH+SLOT_W-1:RECIP_SH];
    end

endmodule

### hw/rtl/sca_queue.sv
// Two-entry command queue between front and back.
module sca_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sca_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sca_pkg::t_cmd o_cmd
);
    import sca_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### hw/rtl/sca_back.sv
// Back end: free-list memory, page heads, command execution and result register.
module sca_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  sca_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_busy_clear,
    output logic           o_valid,
    input  logic           i_stall,
    output sca_pkg::t_out  o_data
);
    import sca_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_LINK, S_FREE} t_state;

    t_state            r_state;
    logic [MEM_AW-1:0] r_clr;
    t_cmd              r_cmd;
    logic [PG_W-1:0]   r_pg;
    logic [PAGE_W-1:0] r_gp;
    logic [SLOT_W-1:0] r_slot;
    logic [LINK_W-1:0] r_head [32];
    logic [LINK_W-1:0] r_rd;
    logic [LINK_W-1:0] mem [1 << MEM_AW];
    logic              r_valid;
    t_out              r_data;

    logic [PAGE_W-1:0] scan_gp;
    logic [PAGE_W-1:0] head_idx;
    logic [LINK_W-1:0] head;
    logic              we;
    logic [MEM_AW-1:0] wa;
    logic [LINK_W-1:0] wd;
    logic [LINK_W-1:0] clr_next;
    logic [LINK_W-1:0] clr_val;
    logic [12:0]       blk_idx;
    logic [16:0]       granted;

    assign scan_gp  = {r_cmd.cls, r_pg};
    assign head_idx = (r_state == S_FREE) ? r_cmd.gp : scan_gp;
    assign head     = r_head[head_idx];

    // Reset value of a link during the clearing pass
    assign clr_next = 10'(r_clr[SLOT_W-1:0]) + 10'd1;
    assign clr_val  = (clr_next < slots_in_page(r_clr[MEM_AW-1:MEM_AW-CLS_W]))
                      ? clr_next : LINK_NULL;

    // Link memory write port
    always_comb begin
        we = 1'b0;
        wa = r_clr;
        wd = clr_val;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (r_state == S_FREE &&
                     10'(r_cmd.slot) < slots_in_page(r_cmd.cls)) begin
            we = 1'b1;
            wa = {r_cmd.gp, r_cmd.slot};
            wd = head;
        end
    end

    // Link memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[{scan_gp, head[SLOT_W-1:0]}];
    end

    assign blk_idx = 13'(r_slot) * 13'({1'b0, r_cmd.cls} + 4'd1);
    assign granted = {r_gp, 12'd0} + {1'b0, blk_idx, 3'd0};

    assign o_pop        = (r_state == S_IDLE) && i_cmd_valid && !r_valid;
    assign o_busy_clear = (r_state == S_CLEAR);
    assign o_valid      = r_valid;
    assign o_data       = r_data;

    // Sequence commands, update heads and hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_pg    <= '0;
            for (int i = 0; i < 32; i++) r_head[i] <= '0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        r_pg  <= '0;
                        if (i_cmd.op == OP_FREE) begin
                            r_state <= S_FREE;
                        end else if (i_cmd.bad_size) begin
                            r_valid <= 1'b1;
                            r_data  <= '{granted_offset: '0, status: ST_BAD_SIZE};
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!head[LINK_W-1]) begin
                        r_gp    <= scan_gp;
                        r_slot  <= head[SLOT_W-1:0];
                        r_state <= S_LINK;
                    end else if (&r_pg) begin
                        r_valid <= 1'b1;
                        r_data  <= '{granted_offset: '0, status: ST_EXHAUSTED};
                        r_state <= S_IDLE;
                    end else begin
                        r_pg <= r_pg + 1'b1;
                    end
                end
                S_LINK: begin
                    r_head[r_gp] <= r_rd;
                    r_valid <= 1'b1;
                    r_data  <= '{granted_offset: granted, status: ST_OK};
                    r_state <= S_IDLE;
                end
                S_FREE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (we) begin
                        r_head[r_cmd.gp] <= 10'(r_cmd.slot);
                        r_data <= '{granted_offset: '0, status: ST_OK};
                    end else begin
                        r_data <= '{granted_offset: '0, status: ST_BAD_OFFSET};
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hw/rtl/size_class_slab_allocator_unit.sv
// Top level of the size-class slab allocator.
// Usage:
//   Requests enter on i_valid/o_stall with payload i_data (allocate or free).
//   Results leave on o_valid/i_stall with payload o_data, one per request,
//   in request order.
//   A request is classified in the transfer cycle and queued (two entries).
//   The back end then takes it: an allocate passes through taking the
//   command, a scan of up to four page heads and the link memory read (a
//   scan that finds no free slot ends without the read); a free takes the
//   command and writes the link if the slot is in range, and a bad size is
//   answered as the command is taken. The result must leave before the next
//   command is taken, so the back end serves one request at a time; the
//   page-head scan sets the rate.
//   After reset the link memory is rewritten to full chains in a clearing
//   pass over all 16384 entries; o_stall stays high during it.
//   While the receiver stalls, the result holds and the back end waits;
//   the queue takes up to two more requests, then o_stall rises.
module size_class_slab_allocator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sca_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output sca_pkg::t_out  o_data
);
    import sca_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_full;
    logic q_valid;
    logic pop;
    logic clearing;
    logic push;

    assign o_stall = q_full || clearing;
    assign push    = i_valid && !o_stall;

    sca_front u_front (
        .i_req (i_data),
        .o_cmd (front_cmd)
    );

    sca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    sca_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_busy_clear (clearing),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.granted_offset == '0)
        else $error("failed result carries an offset");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("result or readiness right after reset");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid && !o_valid && !clearing)
        else $error("command popped while result pending");
`endif

endmodule
